FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with asynchronous reset disable.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/core/rlmrs_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED matrix row scanner package
// Shared types and constants for the row scanner.
// ----------------------------------------------------------------------------
package rlmrs_pkg;

	localparam int COLUMNS_DEF = 64;
	localparam int ROWS_DEF    = 32;

	localparam int COLUMN_W   = 6;
	localparam int PIX_Y_W    = 5;
	localparam int COMP_W     = 8;
	localparam int RGB_W      = 3;
	localparam int ROW_ADDR_W = 4;
	localparam int PERIOD_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [PERIOD_W-1:0] ROW_PERIOD_RST   = 16'd500;
	localparam logic [COMP_W-1:0]   ON_THRESHOLD_RST = 8'd127;

	localparam logic [RGB_W-1:0] RGB_RED   = 3'b001;
	localparam logic [RGB_W-1:0] RGB_GREEN = 3'b010;
	localparam logic [RGB_W-1:0] RGB_BLUE  = 3'b100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_PERIOD   = 1'b0,
		CFG_ON_THRESHOLD = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_TICK  = 1'b1
	} func_t;

	typedef struct packed {
		logic                func;
		logic [COLUMN_W-1:0] pixel_x;
		logic [PIX_Y_W-1:0]  pixel_y;
		logic [COMP_W-1:0]   red;
		logic [COMP_W-1:0]   green;
		logic [COMP_W-1:0]   blue;
	} item_t;

	typedef struct packed {
		logic [COLUMN_W-1:0]   shift_column;
		logic [RGB_W-1:0]      upper_rgb;
		logic [RGB_W-1:0]      lower_rgb;
		logic [ROW_ADDR_W-1:0] row_address;
		logic                  latch_row;
	} result_t;

	typedef struct packed {
		logic clear;
		logic read;
	} mem_ctl_t;

endpackage

FILE: rtl/core/rlmrs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module rlmrs_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/rlmrs_seq.sv
// ----------------------------------------------------------------------------
// Row scanner sequencer
// Clears the pixel memories after reset, counts ticks and streams one row
// pair out of the memories when the row period elapses.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlmrs_seq #(
	parameter int COLUMNS = rlmrs_pkg::COLUMNS_DEF,
	parameter int ROWS    = rlmrs_pkg::ROWS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  rlmrs_pkg::item_t                          item,
	input  logic [rlmrs_pkg::PERIOD_W-1:0]            row_period,
	input  logic [rlmrs_pkg::RGB_W-1:0]               upper_data,
	input  logic [rlmrs_pkg::RGB_W-1:0]               lower_data,
	output logic                                      busy,
	output rlmrs_pkg::mem_ctl_t                       mem_ctl,
	output logic [$clog2(COLUMNS*(ROWS/2))-1:0]       mem_addr,
	output rlmrs_pkg::result_t                        result,
	output logic                                      result_strobe
);

	import rlmrs_pkg::*;

	localparam int HALF_ROWS = ROWS / 2;
	localparam int DEPTH     = COLUMNS * HALF_ROWS;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(COLUMNS);
	localparam int RW        = $clog2(HALF_ROWS);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_SCAN  = 3'b100
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       addr_q;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic [PERIOD_W-1:0] tick_q;
	logic                strobe_s1;
	logic                last_s1;
	logic [CW-1:0]       col_s1;

	logic                tick;
	logic [PERIOD_W-1:0] tick_next;
	logic [PERIOD_W-1:0] period;
	logic                refresh;
	logic [RW-1:0]       row_next;
	logic                col_last;

	assign busy      = (state_q != S_IDLE);
	assign tick      = start && !busy && (item.func == FUNC_TICK);
	assign tick_next = tick_q + PERIOD_W'(1);
	assign period    = (row_period == '0) ? PERIOD_W'(1) : row_period;
	assign refresh   = tick && (tick_next >= period);
	assign row_next  = (row_q == RW'(HALF_ROWS - 1)) ? '0 : row_q + RW'(1);
	assign col_last  = (col_q == CW'(COLUMNS - 1));

	assign mem_ctl.clear = (state_q == S_CLEAR);
	assign mem_ctl.read  = (state_q == S_SCAN);
	assign mem_addr      = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			addr_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
			tick_q    <= '0;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			strobe_s1 <= (state_q == S_SCAN);
			last_s1   <= (state_q == S_SCAN) && col_last;
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (tick) begin
						if (refresh) begin
							tick_q  <= '0;
							row_q   <= row_next;
							addr_q  <= AW'(32'(row_next) * COLUMNS);
							col_q   <= '0;
							state_q <= S_SCAN;
						end else begin
							tick_q <= tick_next;
						end
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + AW'(1);
					col_q  <= col_q + CW'(1);
					if (col_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_q;
	end

	assign result_strobe       = strobe_s1;
	assign result.shift_column = COLUMN_W'(col_s1);
	assign result.upper_rgb    = upper_data;
	assign result.lower_rgb    = lower_data;
	assign result.row_address  = last_s1 ? ROW_ADDR_W'(row_q) : '0;
	assign result.latch_row    = last_s1;

	`ASSERT_NEVER(a_latch_needs_strobe, clk, arst_n, result.latch_row && !result_strobe,
		"Latch marker seen outside a result transaction.")
	`ASSERT_PROP(a_scan_starts_col0, clk, arst_n,
		(state_q == S_SCAN && $past(state_q) != S_SCAN) |-> (col_q == '0),
		"Row scan did not start at column zero.")
	`ASSERT_PROP(a_gap_after_latch, clk, arst_n,
		(result_strobe && result.latch_row) |=> !result_strobe,
		"Result transaction directly after the latch marker.")
	`ASSERT_NEVER(a_no_strobe_in_clear, clk, arst_n, result_strobe && mem_ctl.clear,
		"Result transaction during the memory clearing pass.")

endmodule

FILE: rtl/core/rgb_led_matrix_row_scanner.sv
// A pixel write is taken straight into a pixel memory. A tick that ends a row
// period streams COLUMNS results, one per cycle, via S_SCAN and the read registers.
// Throughput: one write or tick per cycle; busy holds during a row burst.
// Reset: a clearing pass over all COLUMNS*ROWS/2 addresses (1024 by default) blacks
// both pixel memories, one address of each per cycle, with busy high.
// The receiver cannot stall: each result is shown for one strobed cycle.
// ----------------------------------------------------------------------------
// RGB LED matrix row scanner
// Stores thresholded pixels in two half-panel memories and shifts out one
// row pair per row period.
// ----------------------------------------------------------------------------
module rgb_led_matrix_row_scanner #(
	parameter int COLUMNS = rlmrs_pkg::COLUMNS_DEF,
	parameter int ROWS    = rlmrs_pkg::ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  rlmrs_pkg::item_t                  item,
	output rlmrs_pkg::result_t                result,
	output logic                              result_strobe,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rlmrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rlmrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import rlmrs_pkg::*;

	localparam int HALF_ROWS = ROWS / 2;
	localparam int DEPTH     = COLUMNS * HALF_ROWS;
	localparam int AW        = $clog2(DEPTH);

	logic [PERIOD_W-1:0] row_period_q;
	logic [COMP_W-1:0]   on_threshold_q;

	mem_ctl_t         mem_ctl;
	logic [AW-1:0]    seq_addr;
	logic [RGB_W-1:0] upper_data;
	logic [RGB_W-1:0] lower_data;

	logic             pix_wr;
	logic             in_range;
	logic             upper_half;
	logic [31:0]      row_in_half;
	logic [AW-1:0]    pix_addr;
	logic [RGB_W-1:0] pix_rgb;
	logic [AW-1:0]    waddr;
	logic [RGB_W-1:0] wdata;
	logic             we_upper;
	logic             we_lower;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_period_q   <= ROW_PERIOD_RST;
			on_threshold_q <= ON_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_PERIOD:   row_period_q   <= cfg_data[PERIOD_W-1:0];
				CFG_ON_THRESHOLD: on_threshold_q <= cfg_data[COMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign pix_wr      = start && !busy && (item.func == FUNC_WRITE);
	assign in_range    = (32'(item.pixel_x) < COLUMNS) && (32'(item.pixel_y) < 2 * HALF_ROWS);
	assign upper_half  = (32'(item.pixel_y) < HALF_ROWS);
	assign row_in_half = upper_half ? 32'(item.pixel_y) : 32'(item.pixel_y) - HALF_ROWS;
	assign pix_addr    = AW'(row_in_half * COLUMNS + 32'(item.pixel_x));
	assign pix_rgb     = ((item.red > on_threshold_q) ? RGB_RED : '0)
	                   | ((item.green > on_threshold_q) ? RGB_GREEN : '0)
	                   | ((item.blue > on_threshold_q) ? RGB_BLUE : '0);

	assign waddr    = mem_ctl.clear ? seq_addr : pix_addr;
	assign wdata    = mem_ctl.clear ? '0 : pix_rgb;
	assign we_upper = mem_ctl.clear || (pix_wr && in_range && upper_half);
	assign we_lower = mem_ctl.clear || (pix_wr && in_range && !upper_half);

	rlmrs_ram #(
		.WIDTH(RGB_W),
		.DEPTH(DEPTH)
	) u_upper_ram (
		.clk  (clk),
		.we   (we_upper),
		.waddr(waddr),
		.wdata(wdata),
		.re   (mem_ctl.read),
		.raddr(seq_addr),
		.rdata(upper_data)
	);

	rlmrs_ram #(
		.WIDTH(RGB_W),
		.DEPTH(DEPTH)
	) u_lower_ram (
		.clk  (clk),
		.we   (we_lower),
		.waddr(waddr),
		.wdata(wdata),
		.re   (mem_ctl.read),
		.raddr(seq_addr),
		.rdata(lower_data)
	);

	rlmrs_seq #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.row_period   (row_period_q),
		.upper_data   (upper_data),
		.lower_data   (lower_data),
		.busy         (busy),
		.mem_ctl      (mem_ctl),
		.mem_addr     (seq_addr),
		.result       (result),
		.result_strobe(result_strobe)
	);

endmodule
